[src/kts_pkg.sv]
// shared types, token codes and character classification for the keyword token scanner
// no dependencies; used by every module under src
package kts_pkg;

  localparam int MaxLineLength = 1024;
  localparam int QueueDepth    = 4;
  localparam int LenW          = 11;
  localparam int LineW         = 16;
  localparam int KindW         = 5;
  localparam int PrefixW       = 40;
  localparam int NumKeywords   = 6;

  typedef enum logic [KindW-1:0] {
    TK_EOI    = 5'd0,
    TK_SEMI   = 5'd1,
    TK_PLUS   = 5'd2,
    TK_MINUS  = 5'd3,
    TK_TIMES  = 5'd4,
    TK_DIV    = 5'd5,
    TK_LP     = 5'd6,
    TK_RP     = 5'd7,
    TK_GT     = 5'd8,
    TK_LT     = 5'd9,
    TK_EQUALS = 5'd10,
    TK_COLON  = 5'd11,
    TK_IF     = 5'd12,
    TK_THEN   = 5'd13,
    TK_WHILE  = 5'd14,
    TK_DO     = 5'd15,
    TK_BEGIN  = 5'd16,
    TK_END    = 5'd17,
    TK_NUMBER = 5'd18,
    TK_IDENT  = 5'd19,
    TK_BAD    = 5'd20
  } tok_kind_t;

  // one queue entry: the tokens one item causes, word token first
  typedef struct packed {
    logic              has_word;
    tok_kind_t         word_kind;
    logic [LenW-1:0]   word_len;
    logic              has_tok;
    tok_kind_t         tok_kind;
    logic [LenW-1:0]   tok_len;
    logic [LineW-1:0]  line;
  } entry_t;

  // keyword spellings, first character in the low byte
  localparam logic [PrefixW-1:0] KW_TEXT [NumKeywords] = '{
    40'h00_0000_6669,  // if
    40'h00_6E65_6874,  // then
    40'h65_6C69_6877,  // while
    40'h00_0000_6F64,  // do
    40'h6E_6967_6562,  // begin
    40'h00_0064_6E65   // end
  };
  localparam logic [LenW-1:0] KW_LEN [NumKeywords] = '{
    11'd2, 11'd4, 11'd5, 11'd2, 11'd5, 11'd3
  };

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // TK_EOI means not an operator
  function automatic tok_kind_t operator_kind(logic [7:0] c);
    tok_kind_t k;
    unique case (c)
      8'h3B:   k = TK_SEMI;
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_TIMES;
      8'h2F:   k = TK_DIV;
      8'h28:   k = TK_LP;
      8'h29:   k = TK_RP;
      8'h3E:   k = TK_GT;
      8'h3C:   k = TK_LT;
      8'h3D:   k = TK_EQUALS;
      8'h3A:   k = TK_COLON;
      default: k = TK_EOI;
    endcase
    return k;
  endfunction

  function automatic tok_kind_t word_kind(logic [PrefixW-1:0] prefix, logic [LenW-1:0] len,
                                          logic all_digits);
    tok_kind_t k;
    k = all_digits ? TK_NUMBER : TK_IDENT;
    for (int i = NumKeywords - 1; i >= 0; i--) begin
      if ((len == KW_LEN[i]) && (prefix == KW_TEXT[i])) begin
        k = tok_kind_t'(KindW'(int'(TK_IF) + i));
      end
    end
    return k;
  endfunction

endpackage

[src/kts_front.sv]
// front end: accepts characters, keeps the current word and line count, builds queue entries
// depends on kts_pkg
module kts_front #(
  parameter int MAX_LINE_LENGTH = kts_pkg::MaxLineLength
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     char_valid,
  output logic                     char_stall,
  input  logic [7:0]               char_code,
  input  logic                     end_of_input,
  input  logic                     q_full,
  output logic                     push,
  output kts_pkg::entry_t          push_entry
);

  localparam int WordLimit = (MAX_LINE_LENGTH < 2047) ? MAX_LINE_LENGTH : 2047;

  logic [kts_pkg::PrefixW-1:0] word_prefix, word_prefix_next;
  logic [kts_pkg::LenW-1:0]    word_length, word_length_next;
  logic                        word_all_digits, word_all_digits_next;
  logic [kts_pkg::LineW-1:0]   line_count, line_count_next;

  logic                accept;
  logic                alnum;
  kts_pkg::tok_kind_t  op;
  kts_pkg::entry_t     e;

  assign char_stall = q_full;
  assign accept     = char_valid && !q_full;
  assign alnum      = kts_pkg::is_alnum(char_code);
  assign op         = kts_pkg::operator_kind(char_code);

  always_comb begin
    e                    = '0;
    e.line               = line_count;
    e.word_kind          = kts_pkg::word_kind(word_prefix, word_length, word_all_digits);
    e.word_len           = word_length;
    e.tok_kind           = kts_pkg::TK_BAD;
    e.tok_len            = kts_pkg::LenW'(1);
    word_prefix_next     = word_prefix;
    word_length_next     = word_length;
    word_all_digits_next = word_all_digits;
    line_count_next      = line_count;
    if (end_of_input) begin
      e.has_word = (word_length != '0);
      e.has_tok  = 1'b1;
      e.tok_kind = kts_pkg::TK_EOI;
      e.tok_len  = '0;
    end else if (!alnum) begin
      e.has_word = (word_length != '0);
      if (op != kts_pkg::TK_EOI) begin
        e.has_tok  = 1'b1;
        e.tok_kind = op;
      end else if (char_code == kts_pkg::CH_NEWLINE) begin
        if (line_count != '1) begin
          line_count_next = line_count + kts_pkg::LineW'(1);
        end
      end else if ((char_code != kts_pkg::CH_SPACE) && (char_code != kts_pkg::CH_TAB)) begin
        e.has_tok = 1'b1;
      end
    end
    if (end_of_input || !alnum) begin
      word_prefix_next     = '0;
      word_length_next     = '0;
      word_all_digits_next = 1'b1;
    end else begin
      // first five characters land in byte slot word_length
      for (int i = 0; i < 5; i++) begin
        if (word_length == kts_pkg::LenW'(i)) begin
          word_prefix_next[8*i +: 8] = char_code;
        end
      end
      if (!kts_pkg::is_digit(char_code)) begin
        word_all_digits_next = 1'b0;
      end
      if (word_length < kts_pkg::LenW'(WordLimit)) begin
        word_length_next = word_length + kts_pkg::LenW'(1);
      end
    end
  end

  assign push       = accept && (e.has_word || e.has_tok);
  assign push_entry = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_prefix     <= '0;
      word_length     <= '0;
      word_all_digits <= 1'b1;
      line_count      <= kts_pkg::LineW'(1);
    end else if (accept) begin
      word_prefix     <= word_prefix_next;
      word_length     <= word_length_next;
      word_all_digits <= word_all_digits_next;
      line_count      <= line_count_next;
    end
  end

endmodule

[src/kts_queue.sv]
// small entry queue between the front end and the token emitter
// depends on kts_pkg
module kts_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  kts_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output kts_pkg::entry_t  head
);

  localparam int PtrW = $clog2(kts_pkg::QueueDepth);
  localparam int CntW = PtrW + 1;

  kts_pkg::entry_t slots [kts_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(kts_pkg::QueueDepth));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[src/kts_back.sv]
// back end: splits each queue entry into tokens and holds them in the output register
// depends on kts_pkg
module kts_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  kts_pkg::entry_t               head,
  output logic                          pop,
  output logic                          token_valid,
  input  logic                          token_stall,
  output logic [kts_pkg::KindW-1:0]     token_kind,
  output logic [kts_pkg::LenW-1:0]      lexeme_length,
  output logic [kts_pkg::LineW-1:0]     line_number,
  output logic                          is_last
);

  logic phase;  // word token of the head entry already sent
  logic load;
  logic emit_word;

  assign load      = q_valid && (!token_valid || !token_stall);
  assign emit_word = head.has_word && !phase;
  assign pop       = load && !(emit_word && head.has_tok);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      phase       <= 1'b0;
    end else begin
      if (load) begin
        token_valid <= 1'b1;
        phase       <= !pop;
      end else if (!token_stall) begin
        token_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind    <= emit_word ? head.word_kind : head.tok_kind;
      lexeme_length <= emit_word ? head.word_len : head.tok_len;
      line_number   <= head.line;
      is_last       <= pop;
    end
  end

endmodule

[src/keyword_token_scanner_core.sv]
// Streaming keyword scanner: one character (or an end-of-input mark) is taken per cycle on
// the char channel while the queue has room, and tokens leave on the token channel one per
// cycle while token_stall is low. The front end classifies each character in the cycle it is
// accepted and writes the tokens it causes into a four-entry queue; the emitter reads one
// entry and sends its tokens one after the other, word token first. Characters inside a word
// cause no token and need no queue slot. Sustained input rate is one item per cycle while the
// token side keeps up; the token side, at one token per cycle, sets the rate otherwise.
// An accepted item's first token passes through its queue slot and then the output register.
// depends on kts_pkg, kts_front, kts_queue, kts_back
module keyword_token_scanner_core #(
  parameter int MAX_LINE_LENGTH = kts_pkg::MaxLineLength
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          char_valid,
  output logic                          char_stall,
  input  logic [7:0]                    char_code,
  input  logic                          end_of_input,
  output logic                          token_valid,
  input  logic                          token_stall,
  output logic [kts_pkg::KindW-1:0]     token_kind,
  output logic [kts_pkg::LenW-1:0]      lexeme_length,
  output logic [kts_pkg::LineW-1:0]     line_number,
  output logic                          is_last
);

  logic            q_full;
  logic            push;
  kts_pkg::entry_t push_entry;
  logic            pop;
  logic            q_valid;
  kts_pkg::entry_t head;

  kts_front #(
    .MAX_LINE_LENGTH(MAX_LINE_LENGTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  kts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  kts_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .token_kind    (token_kind),
    .lexeme_length (lexeme_length),
    .line_number   (line_number),
    .is_last       (is_last)
  );

endmodule

[tb/kts_checker.sv]
// token checker for keyword_token_scanner_core: keeps its own scanner state, predicts the
// tokens of every accepted item and compares them in order with the tokens handed out
// depends on kts_pkg
`timescale 1ns / 1ps

module kts_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       char_valid,
  input  logic                       char_stall,
  input  logic [7:0]                 char_code,
  input  logic                       end_of_input,
  input  logic                       token_valid,
  input  logic                       token_stall,
  input  logic [kts_pkg::KindW-1:0]  token_kind,
  input  logic [kts_pkg::LenW-1:0]   lexeme_length,
  input  logic [kts_pkg::LineW-1:0]  line_number,
  input  logic                       is_last,
  output int                         fail_count,
  output int                         pending,
  output int                         tokens_checked
);

  localparam int WordLimit = (kts_pkg::MaxLineLength < 2047) ? kts_pkg::MaxLineLength : 2047;

  typedef struct packed {
    kts_pkg::tok_kind_t         kind;
    logic [kts_pkg::LenW-1:0]   len;
    logic [kts_pkg::LineW-1:0]  line;
    logic                       last;
  } token_t;

  token_t expected_tokens[$];

  // scanner state as the block should hold it
  logic [kts_pkg::PrefixW-1:0] word_text;
  logic [kts_pkg::LenW-1:0]    word_len;
  logic                        word_digits;
  logic [kts_pkg::LineW-1:0]   line_cnt;

  int mismatches = 0;
  int checked = 0;

  function automatic logic char_is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic char_is_alnum(logic [7:0] c);
    return char_is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // TK_EOI stands for no operator here
  function automatic kts_pkg::tok_kind_t operator_token(logic [7:0] c);
    case (c)
      ";":     return kts_pkg::TK_SEMI;
      "+":     return kts_pkg::TK_PLUS;
      "-":     return kts_pkg::TK_MINUS;
      "*":     return kts_pkg::TK_TIMES;
      "/":     return kts_pkg::TK_DIV;
      "(":     return kts_pkg::TK_LP;
      ")":     return kts_pkg::TK_RP;
      ">":     return kts_pkg::TK_GT;
      "<":     return kts_pkg::TK_LT;
      "=":     return kts_pkg::TK_EQUALS;
      ":":     return kts_pkg::TK_COLON;
      default: return kts_pkg::TK_EOI;
    endcase
  endfunction

  function automatic string keyword_name(int k);
    case (k)
      0:       return "if";
      1:       return "then";
      2:       return "while";
      3:       return "do";
      4:       return "begin";
      default: return "end";
    endcase
  endfunction

  function automatic kts_pkg::tok_kind_t classify_word();
    kts_pkg::tok_kind_t k;
    logic [kts_pkg::PrefixW-1:0] text;
    string s;
    k = word_digits ? kts_pkg::TK_NUMBER : kts_pkg::TK_IDENT;
    for (int i = 0; i < kts_pkg::NumKeywords; i++) begin
      s = keyword_name(i);
      text = '0;
      for (int j = 0; j < s.len(); j++) text[8*j +: 8] = s[j];
      if ((word_len == s.len()) && (word_text == text)) begin
        k = kts_pkg::tok_kind_t'(int'(kts_pkg::TK_IF) + i);
      end
    end
    return k;
  endfunction

  function automatic token_t make_token(kts_pkg::tok_kind_t k, logic [kts_pkg::LenW-1:0] len);
    token_t t;
    t.kind = k;
    t.len  = len;
    t.line = line_cnt;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic token_t take_word();
    token_t t;
    t = make_token(classify_word(), word_len);
    word_text   = '0;
    word_len    = '0;
    word_digits = 1'b1;
    return t;
  endfunction

  task automatic scan_item(input logic [7:0] c, input logic eoi);
    token_t burst[2];
    int n;
    kts_pkg::tok_kind_t op;
    n  = 0;
    op = operator_token(c);
    if (eoi) begin
      if (word_len != 0) begin
        burst[n] = take_word();
        n++;
      end
      burst[n] = make_token(kts_pkg::TK_EOI, '0);
      n++;
    end else if (char_is_alnum(c)) begin
      if (word_len < 5) word_text[8*word_len +: 8] = c;
      if (!char_is_digit(c)) word_digits = 1'b0;
      if (word_len < WordLimit) word_len++;
    end else begin
      if (word_len != 0) begin
        burst[n] = take_word();
        n++;
      end
      if (op != kts_pkg::TK_EOI) begin
        burst[n] = make_token(op, kts_pkg::LenW'(1));
        n++;
      end else if (c == 8'h0A) begin
        // word above already took the old line
        if (line_cnt != '1) line_cnt++;
      end else if ((c != " ") && (c != "\t")) begin
        burst[n] = make_token(kts_pkg::TK_BAD, kts_pkg::LenW'(1));
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      burst[i].last = (i == n - 1);
      expected_tokens.push_back(burst[i]);
    end
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    if (rst) begin
      expected_tokens.delete();
      word_text   = '0;
      word_len    = '0;
      word_digits = 1'b1;
      line_cnt    = kts_pkg::LineW'(1);
    end else begin
      // tokens first: an item taken at this edge cannot have produced one yet
      if (token_valid && !token_stall) begin
        checked++;
        if (expected_tokens.size() == 0) begin
          $error("token with no item behind it: token_kind %0d", token_kind);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind !== want.kind) begin
            $error("token_kind expected %0d actual %0d", want.kind, token_kind);
            mismatches++;
          end
          if (lexeme_length !== want.len) begin
            $error("lexeme_length expected %0d actual %0d", want.len, lexeme_length);
            mismatches++;
          end
          if (line_number !== want.line) begin
            $error("line_number expected %0d actual %0d", want.line, line_number);
            mismatches++;
          end
          if (is_last !== want.last) begin
            $error("is_last expected %0d actual %0d", want.last, is_last);
            mismatches++;
          end
        end
      end
      if (char_valid && !char_stall) scan_item(char_code, end_of_input);
    end
    fail_count     <= mismatches;
    pending        <= expected_tokens.size();
    tokens_checked <= checked;
  end

endmodule

[tb/testbench.sv]
// top of the scanner testbench: clock, reset, character stimulus and token-side stalls
// depends on kts_pkg, keyword_token_scanner_core and kts_checker
`timescale 1ns / 1ps

module testbench;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       char_valid;
  logic                       char_stall;
  logic [7:0]                 char_code;
  logic                       end_of_input;
  logic                       token_valid;
  logic                       token_stall;
  logic [kts_pkg::KindW-1:0]  token_kind;
  logic [kts_pkg::LenW-1:0]   lexeme_length;
  logic [kts_pkg::LineW-1:0]  line_number;
  logic                       is_last;

  int fail_count;
  int pending;
  int tokens_checked;

  int items_sent = 0;
  bit no_idle = 1'b0;
  bit long_hold = 1'b0;
  string op_chars = ";+-*/()><=:";

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keyword_token_scanner_core DUT (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_code     (char_code),
    .end_of_input  (end_of_input),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .token_kind    (token_kind),
    .lexeme_length (lexeme_length),
    .line_number   (line_number),
    .is_last       (is_last)
  );

  kts_checker u_token_check (
    .clk            (clk),
    .rst            (rst),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_code      (char_code),
    .end_of_input   (end_of_input),
    .token_valid    (token_valid),
    .token_stall    (token_stall),
    .token_kind     (token_kind),
    .lexeme_length  (lexeme_length),
    .line_number    (line_number),
    .is_last        (is_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .tokens_checked (tokens_checked)
  );

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  // returns at the edge where the item is taken
  task automatic offer_char(input logic [7:0] c, input logic eoi);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid   <= 1'b1;
    char_code    <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic offer_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_char(s[i], 1'b0);
  endtask

  task automatic offer_eoi();
    offer_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] random_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                : 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  function automatic logic [7:0] random_alnum();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'h30, 8'h39)) : random_letter();
  endfunction

  function automatic logic [7:0] random_bad();
    string odd;
    odd = "!\"#$%&',.?@[\\]^_`{|}~";
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(128, 255));
      1:       return 8'($urandom_range(0, 8));
      2:       return 8'($urandom_range(11, 31));
      3:       return odd[$urandom_range(0, odd.len() - 1)];
      default: return 8'h7F;
    endcase
  endfunction

  function automatic string pick_keyword();
    case ($urandom_range(0, 5))
      0:       return "if";
      1:       return "then";
      2:       return "while";
      3:       return "do";
      4:       return "begin";
      default: return "end";
    endcase
  endfunction

  task automatic offer_delimiter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      offer_char(op_chars[$urandom_range(0, 10)], 1'b0);
    else if (r < 70) offer_char(" ", 1'b0);
    else if (r < 78) offer_char("\t", 1'b0);
    else if (r < 90) offer_char(8'h0A, 1'b0);
    else if (r < 96) offer_char(random_bad(), 1'b0);
    else             offer_eoi();
  endtask

  // mostly source-like text: a word, then whatever ends it
  task automatic random_phrase();
    int r;
    int n;
    string w;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      offer_char(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      if (r < 40) begin
        offer_text(pick_keyword());
      end else if (r < 58) begin
        n = $urandom_range(1, 9);
        offer_char(random_letter(), 1'b0);
        repeat (n - 1) offer_char(random_alnum(), 1'b0);
      end else if (r < 72) begin
        n = $urandom_range(1, 6);
        repeat (n) offer_char(8'($urandom_range(8'h30, 8'h39)), 1'b0);
      end else if (r < 84) begin
        // near misses of a keyword
        w = pick_keyword();
        case ($urandom_range(0, 2))
          0:       w = {w, "x"};
          1:       w = w.substr(0, w.len() - 2);
          default: w = w.toupper();
        endcase
        offer_text(w);
      end
      offer_delimiter();
    end
  endtask

  // token side: random stalls per item, one long hold on request
  initial begin : token_sink
    int w;
    token_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        token_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
        w = 0;
      end else begin
        w = draw_gap();
      end
      if (w > 0) begin
        token_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      token_stall <= 1'b0;
      @(posedge clk);
      while (!token_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int start;
    int guard;
    rst          = 1'b1;
    char_valid   = 1'b0;
    char_code    = '0;
    end_of_input = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: keywords ended by operator and newline, word flushed by end of input,
    // bad bytes, empty flushes, end of input carrying a letter
    offer_text("if;");
    offer_text("do\n");
    offer_text("end(");
    offer_text("42");
    offer_eoi();
    offer_char(8'h00, 1'b0);
    offer_char(8'hFF, 1'b0);
    offer_text(":\t");
    offer_eoi();
    offer_text("x");
    offer_char(8'h7F, 1'b0);
    offer_text("Zz9");
    offer_char("a", 1'b1);

    // receiver holds off while operators keep coming, so the block backs up
    no_idle   = 1'b1;
    long_hold = 1'b1;
    repeat (30) offer_char(op_chars[$urandom_range(0, 10)], 1'b0);
    no_idle = 1'b0;

    start = items_sent;
    while (items_sent - start < 600) begin
      random_phrase();
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
    end
    no_idle = 1'b0;
    offer_eoi();
    char_valid <= 1'b0;

    @(posedge clk);
    guard = 0;
    while ((pending != 0) && (guard < 20000)) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending != 0) $error("%0d expected tokens never arrived", pending);

    $display("run: %0d items sent, %0d tokens checked", items_sent, tokens_checked);
    $display("covered keywords and near misses, numbers, operators, bad bytes, blanks, "
             , "end of input and a long token-side hold");
    if ((fail_count == 0) && (pending == 0)) begin
      $display("PASS keyword_token_scanner_core");
    end else begin
      $display("FAIL keyword_token_scanner_core");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL keyword_token_scanner_core");
    $finish;
  end

endmodule
